FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the decimal text converter.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SID_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SID_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/sid_pkg.sv
// Package for the signed 64-bit to decimal ASCII converter.
// Holds sizes, character codes and the digit cell control struct.
`timescale 1ns / 1ps

package sid_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned NumDigits  = 19;
  localparam int unsigned MaxChars   = 20;
  localparam int unsigned CapWidth   = 8;
  localparam int unsigned LenWidth   = 5;
  localparam int unsigned DigCntW    = $clog2(NumDigits + 1);
  localparam int unsigned BitCntW    = $clog2(ValueWidth);

  localparam logic [7:0]          CharZero  = 8'h30;
  localparam logic [7:0]          CharMinus = 8'h2D;
  localparam logic [CapWidth-1:0] CapReset  = 8'd128;

  typedef struct packed {
    logic clr;
    logic dabble;
    logic dshift;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/signed_int64_to_decimal_ascii.sv
// Converts one signed 64-bit integer per input beat into decimal ASCII text, one character
// per output beat, most significant first, with a leading '-' for negatives. Every text beat
// carries the total length; text that does not fit below the buffer capacity register gives
// one too-long beat instead, with length zero. One value at a time: acceptance, bit-serial
// conversion of the magnitude through a row of 19 BCD digit cells, a step that drops leading
// zeros, then one character per cycle while the output takes beats; an output stall holds
// the block until the beat is taken.
// Uses sid_pkg, sid_digit_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_int64_to_decimal_ascii (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sid_pkg::CapWidth-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [sid_pkg::ValueWidth-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      char_code_o,
  output logic                            is_last_o,
  output logic [sid_pkg::LenWidth-1:0]    text_length_o,
  output logic                            too_long_o
);
  import sid_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_NORM = 5'b00100,
    S_EMIT = 5'b01000,
    S_REJ  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [CapWidth-1:0]   cap_q;
  logic [ValueWidth-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]    ndig_q, ndig_d;
  logic [LenWidth-1:0]   len_q, len_d;
  logic [LenWidth-1:0]   rem_q, rem_d;
  logic                  sign_q, sign_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic [LenWidth-1:0]   olen_q, olen_d;
  logic                  tlong_q, tlong_d;

  logic [ValueWidth-1:0] raw;
  logic [LenWidth-1:0]   len_calc;
  logic                  out_free;
  cell_ctrl_t            ctrl;
  logic [3:0]            digit_w [NumDigits];
  logic                  carry_w [NumDigits];
  logic [3:0]            top_digit;

  assign raw       = value_i;
  assign top_digit = digit_w[NumDigits-1];
  assign out_free  = !out_valid_q || out_ready_i;
  assign len_calc  = LenWidth'(ndig_q) + LenWidth'(neg_q);

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    if (i == 0) begin : g_first
      sid_digit_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .bit_i   (mag_q[ValueWidth-1]),
        .digit_i (4'd0),
        .bit_o   (carry_w[i]),
        .digit_o (digit_w[i])
      );
    end else begin : g_rest
      sid_digit_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .bit_i   (carry_w[i-1]),
        .digit_i (digit_w[i-1]),
        .bit_o   (carry_w[i]),
        .digit_o (digit_w[i])
      );
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    bit_cnt_d   = bit_cnt_q;
    ndig_d      = ndig_q;
    len_d       = len_q;
    rem_d       = rem_q;
    sign_d      = sign_q;
    ctrl        = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    olen_d      = olen_q;
    tlong_d     = tlong_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          neg_d     = raw[ValueWidth-1];
          mag_d     = raw[ValueWidth-1] ? (~raw + 1'b1) : raw;
          bit_cnt_d = '0;
          ctrl.clr  = 1'b1;
          state_d   = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.dabble = 1'b1;
        mag_d       = {mag_q[ValueWidth-2:0], 1'b0};
        bit_cnt_d   = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BitCntW'(ValueWidth - 1)) begin
          ndig_d  = DigCntW'(NumDigits);
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (top_digit == 4'd0 && ndig_q != DigCntW'(1)) begin
          ctrl.dshift = 1'b1;
          ndig_d      = ndig_q - 1'b1;
        end else begin
          len_d  = len_calc;
          rem_d  = len_calc;
          sign_d = neg_q;
          if ({{(CapWidth-LenWidth){1'b0}}, len_calc} >= cap_q) begin
            state_d = S_REJ;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = (rem_q == LenWidth'(1));
          olen_d      = len_q;
          tlong_d     = 1'b0;
          rem_d       = rem_q - 1'b1;
          if (sign_q) begin
            char_d = CharMinus;
            sign_d = 1'b0;
          end else begin
            char_d      = CharZero + {4'd0, top_digit};
            ctrl.dshift = 1'b1;
          end
          if (rem_q == LenWidth'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_REJ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = 8'd0;
          last_d      = 1'b1;
          olen_d      = '0;
          tlong_d     = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      ndig_q      <= '0;
      rem_q       <= '0;
      sign_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      ndig_q      <= ndig_d;
      rem_q       <= rem_d;
      sign_q      <= sign_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    len_q   <= len_d;
    char_q  <= char_d;
    last_q  <= last_d;
    olen_q  <= olen_d;
    tlong_q <= tlong_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign char_code_o   = char_q;
  assign is_last_o     = last_q;
  assign text_length_o = olen_q;
  assign too_long_o    = tlong_q;

  `SID_ASSERT(a_accept_conv, clk_i, rst_ni, in_valid_i && in_ready_o |=> state_q == S_CONV, "accepted beat did not start conversion")
  `SID_NEVER(a_no_overflow, clk_i, rst_ni, state_q == S_CONV && carry_w[NumDigits-1], "digit row overflowed")
  `SID_NEVER(a_emit_rem, clk_i, rst_ni, state_q == S_EMIT && rem_q == '0, "emitting with no characters left")
  `SID_ASSERT(a_reject_beat, clk_i, rst_ni, out_valid_o && too_long_o |-> is_last_o && text_length_o == '0 && char_code_o == 8'd0, "malformed too-long beat")
  `SID_ASSERT(a_char_set, clk_i, rst_ni, out_valid_o && !too_long_o |-> char_code_o == CharMinus || (char_code_o >= CharZero && char_code_o <= CharZero + 8'd9), "bad character code")

endmodule

FILE: hw/rtl/sid_digit_cell.sv
// One BCD digit cell of the conversion row.
// Adds three and shifts during conversion, moves digits up during normalization and emission; uses sid_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sid_digit_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sid_pkg::cell_ctrl_t ctrl_i,
  input  logic               bit_i,
  input  logic [3:0]         digit_i,
  output logic               bit_o,
  output logic [3:0]         digit_o
);
  import sid_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  always_comb begin
    adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  end

  assign bit_o   = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    if (ctrl_i.clr) begin
      digit_d = 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.dshift) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

  `SID_ASSERT(a_digit_bcd, clk_i, rst_ni, digit_q <= 4'd9, "digit cell left BCD range")
  `SID_ASSERT(a_clr_zero, clk_i, rst_ni, ctrl_i.clr |=> digit_q == 4'd0, "clear did not zero cell")

endmodule
